// ===== hw/rtl/iiee_pkg.sv =====
// shared types and constants of the infix expression evaluator
`timescale 1ns / 1ps
`default_nettype none
package iiee_pkg;
    localparam int STACK_DEPTH = 4;
    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);
    localparam logic [SP_W-1:0] DEPTH_CNT = SP_W'(STACK_DEPTH);

    typedef enum logic [1:0] {OP_ADD = 2'd0, OP_SUB = 2'd1, OP_MUL = 2'd2, OP_DIV = 2'd3} op_t;
    typedef enum logic [1:0] {ST_OK = 2'd0, ST_DIVZERO = 2'd1, ST_MISSING = 2'd2,
        ST_SPARE = 2'd3} status_t;

    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // controller to datapath
    typedef struct packed {
        logic       digit;     // fold digit into accumulator
        logic       flush;     // push pending number
        logic       red_start; // pop operator, start reduction
        logic       push_op;   // stack the new operator
        logic       final_chk; // check value count at end
        logic       clear;     // back to reset state
        logic [3:0] digit_val;
        op_t        op;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic ops_empty;
        logic top_ge;      // top operator precedence >= new operator
        logic red_busy;    // reduction in progress
    } dp_stat_t;
endpackage
`default_nettype wire

// ===== hw/rtl/iiee_if.sv =====
// valid/ready channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface iiee_in_if (input wire logic clk);
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;
    modport source (output valid, char_code, last_char, input ready);
    modport sink (input valid, char_code, last_char, output ready);
endinterface

interface iiee_out_if (input wire logic clk);
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic [1:0]         status;
    modport source (output valid, result_value, status, input ready);
    modport sink (input valid, result_value, status, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/iiee_div.sv =====
// iterative signed 32-bit divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module iiee_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);
    logic [31:0] rem_reg, rem_next, quo_reg, quo_next, den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next, busy_reg, busy_next, done_next, done_reg;
    logic [32:0] trial;

    always_comb
    begin
        rem_next = rem_reg; quo_next = quo_reg; den_next = den_reg;
        cnt_next = cnt_reg; neg_next = neg_reg; busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg, quo_reg[31]} - {1'b0, den_reg};
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend[31] ? (32'd0 - dividend) : dividend;
            den_next = divisor[31] ? (32'd0 - divisor) : divisor;
            neg_next = dividend[31] ^ divisor[31];
            cnt_next = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[30:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/iiee_datapath.sv =====
// stacks, number accumulator, alu and error flag
`timescale 1ns / 1ps
`default_nettype none
module iiee_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire iiee_pkg::dp_cmd_t cmd,
    output iiee_pkg::dp_stat_t     stat,
    output logic [31:0]            result_value,
    output logic [1:0]             status
);
    typedef enum logic [1:0] {PH_IDLE, PH_CALC, PH_WAIT} phase_t;

    logic [31:0] vstk_reg [iiee_pkg::STACK_DEPTH];
    iiee_pkg::op_t ostk_reg [iiee_pkg::STACK_DEPTH];
    logic [iiee_pkg::SP_W-1:0] vcnt_reg, ocnt_reg;
    logic [31:0] acc_reg, lhs_reg, rhs_reg, mul_reg;
    logic        pend_reg;
    logic [1:0]  err_reg;
    iiee_pkg::op_t rop_reg;
    phase_t      rph_reg;   // idle, compute/mul, wait for result
    logic        div_start, div_done;
    logic [31:0] quot;
    logic [iiee_pkg::IDX_W-1:0] otop, vtop, vsec, vpush;
    logic        can_reduce;
    logic [31:0] alu_res;
    logic [35:0] acc_x10;

    assign otop  = iiee_pkg::IDX_W'(ocnt_reg - iiee_pkg::SP_W'(1));
    assign vtop  = iiee_pkg::IDX_W'(vcnt_reg - iiee_pkg::SP_W'(1));
    assign vsec  = iiee_pkg::IDX_W'(vcnt_reg - iiee_pkg::SP_W'(2));
    assign vpush = iiee_pkg::IDX_W'(vcnt_reg);
    assign can_reduce = vcnt_reg >= iiee_pkg::SP_W'(2);
    assign acc_x10 = {acc_reg, 3'b0} + {3'b0, acc_reg, 1'b0};

    assign stat.ops_empty = (ocnt_reg == '0);
    assign stat.top_ge = ostk_reg[otop][1] >= cmd.op[1];
    assign stat.red_busy = (rph_reg != PH_IDLE);

    assign div_start = (rph_reg == PH_CALC) && (rop_reg == iiee_pkg::OP_DIV)
        && (rhs_reg != '0);

    iiee_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(lhs_reg),
        .divisor(rhs_reg), .done(div_done), .quotient(quot)
    );

    always_comb
    begin
        unique case (rop_reg)
            iiee_pkg::OP_ADD: alu_res = lhs_reg + rhs_reg;
            iiee_pkg::OP_SUB: alu_res = lhs_reg - rhs_reg;
            iiee_pkg::OP_MUL: alu_res = mul_reg;
            iiee_pkg::OP_DIV: alu_res = (rhs_reg == '0) ? '0 : quot;
            default:          alu_res = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcnt_reg <= '0; ocnt_reg <= '0; pend_reg <= 1'b0;
            err_reg <= iiee_pkg::ST_OK; rph_reg <= PH_IDLE; acc_reg <= '0;
        end
        else if (cmd.clear)
        begin
            vcnt_reg <= '0; ocnt_reg <= '0; pend_reg <= 1'b0;
            err_reg <= iiee_pkg::ST_OK; rph_reg <= PH_IDLE; acc_reg <= '0;
        end
        else
        begin
            if (cmd.digit)
            begin
                acc_reg  <= acc_x10[31:0] + {28'd0, cmd.digit_val};
                pend_reg <= 1'b1;
            end
            if (cmd.flush && pend_reg)
            begin
                pend_reg <= 1'b0;
                acc_reg  <= '0;
                if (vcnt_reg >= iiee_pkg::DEPTH_CNT)
                begin
                    if (err_reg == iiee_pkg::ST_OK) err_reg <= iiee_pkg::ST_MISSING;
                end
                else
                begin
                    vstk_reg[vpush] <= acc_reg;
                    vcnt_reg <= vcnt_reg + iiee_pkg::SP_W'(1);
                end
            end
            if (cmd.red_start && ocnt_reg != '0)
            begin
                ocnt_reg <= ocnt_reg - iiee_pkg::SP_W'(1);
                if (!can_reduce)
                begin
                    if (err_reg == iiee_pkg::ST_OK) err_reg <= iiee_pkg::ST_MISSING;
                end
                else
                begin
                    rop_reg  <= ostk_reg[otop];
                    rhs_reg  <= vstk_reg[vtop];
                    lhs_reg  <= vstk_reg[vsec];
                    vcnt_reg <= vcnt_reg - iiee_pkg::SP_W'(2);
                    rph_reg  <= PH_CALC;
                end
            end
            if (rph_reg == PH_CALC)
            begin
                mul_reg <= lhs_reg * rhs_reg;
                rph_reg <= PH_WAIT;
            end
            if (rph_reg == PH_WAIT
                && (rop_reg != iiee_pkg::OP_DIV || rhs_reg == '0 || div_done))
            begin
                rph_reg <= PH_IDLE;
                if (rop_reg == iiee_pkg::OP_DIV && rhs_reg == '0 && err_reg == iiee_pkg::ST_OK)
                    err_reg <= iiee_pkg::ST_DIVZERO;
                // two values were popped, so there is room
                vstk_reg[vpush] <= alu_res;
                vcnt_reg <= vcnt_reg + iiee_pkg::SP_W'(1);
            end
            if (cmd.push_op)
            begin
                if (ocnt_reg >= iiee_pkg::DEPTH_CNT)
                begin
                    if (err_reg == iiee_pkg::ST_OK) err_reg <= iiee_pkg::ST_MISSING;
                end
                else
                begin
                    ostk_reg[iiee_pkg::IDX_W'(ocnt_reg)] <= cmd.op;
                    ocnt_reg <= ocnt_reg + iiee_pkg::SP_W'(1);
                end
            end
            if (cmd.final_chk && err_reg == iiee_pkg::ST_OK && vcnt_reg != iiee_pkg::SP_W'(1))
                err_reg <= iiee_pkg::ST_MISSING;
        end
    end

    assign status = err_reg;
    assign result_value = (err_reg == iiee_pkg::ST_OK) ? vstk_reg[0] : '0;
endmodule
`default_nettype wire

// ===== hw/rtl/iiee_ctrl.sv =====
// sequencing state machine of the evaluator
`timescale 1ns / 1ps
`default_nettype none
module iiee_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    iiee_in_if.sink                 in_ch,
    input  wire iiee_pkg::dp_stat_t stat,
    output iiee_pkg::dp_cmd_t       cmd,
    input  wire logic [31:0]        dp_value,
    input  wire logic [1:0]         dp_status,
    iiee_out_if.source              out_ch
);
    typedef enum logic [2:0] {S_IDLE, S_OPRED, S_OPWAIT, S_ENDFLUSH, S_ENDRED, S_ENDWAIT,
        S_CHECK, S_EMIT} state_t;
    state_t state_reg, state_next;
    iiee_pkg::op_t op_reg, op_next;
    logic last_reg, last_next;
    logic ovalid_reg, ovalid_next;
    logic [31:0] oval_reg, oval_next;
    logic [1:0] ostat_reg, ostat_next;
    logic accept, is_op, is_digit;
    iiee_pkg::op_t in_op;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept = in_ch.valid && in_ch.ready;
    assign is_digit = (in_ch.char_code >= iiee_pkg::CH_ZERO)
        && (in_ch.char_code <= iiee_pkg::CH_NINE);

    always_comb
    begin
        is_op = 1'b1;
        in_op = iiee_pkg::OP_ADD;
        unique case (in_ch.char_code)
            iiee_pkg::CH_PLUS:  in_op = iiee_pkg::OP_ADD;
            iiee_pkg::CH_MINUS: in_op = iiee_pkg::OP_SUB;
            iiee_pkg::CH_STAR:  in_op = iiee_pkg::OP_MUL;
            iiee_pkg::CH_SLASH: in_op = iiee_pkg::OP_DIV;
            default:            is_op = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg; op_next = op_reg; last_next = last_reg;
        ovalid_next = ovalid_reg; oval_next = oval_reg; ostat_next = ostat_reg;
        cmd = '0;
        cmd.op = op_reg;
        if (ovalid_reg && out_ch.ready) ovalid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    last_next = in_ch.last_char;
                    if (is_digit)
                    begin
                        cmd.digit = 1'b1;
                        cmd.digit_val = 4'(in_ch.char_code - iiee_pkg::CH_ZERO);
                        state_next = in_ch.last_char ? S_ENDFLUSH : S_IDLE;
                    end
                    else if (is_op)
                    begin
                        cmd.flush = 1'b1;
                        op_next = in_op;
                        state_next = S_OPRED;
                    end
                    else
                        state_next = in_ch.last_char ? S_ENDFLUSH : S_IDLE;
                end
            end
            S_OPRED:
            begin
                if (!stat.ops_empty && stat.top_ge)
                begin
                    cmd.red_start = 1'b1;
                    state_next = S_OPWAIT;
                end
                else
                begin
                    cmd.push_op = 1'b1;
                    state_next = last_reg ? S_ENDFLUSH : S_IDLE;
                end
            end
            S_OPWAIT:
                if (!stat.red_busy) state_next = S_OPRED;
            S_ENDFLUSH:
            begin
                // pending number goes on the stack before any reduction
                cmd.flush = 1'b1;
                state_next = S_ENDRED;
            end
            S_ENDRED:
            begin
                if (!stat.ops_empty)
                begin
                    cmd.red_start = 1'b1;
                    state_next = S_ENDWAIT;
                end
                else
                    state_next = S_CHECK;
            end
            S_ENDWAIT:
                if (!stat.red_busy) state_next = S_ENDRED;
            S_CHECK:
            begin
                cmd.final_chk = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!ovalid_reg || out_ch.ready)
                begin
                    ovalid_next = 1'b1;
                    oval_next = dp_value;
                    ostat_next = dp_status;
                    cmd.clear = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; ovalid_reg <= 1'b0;
            op_reg <= iiee_pkg::OP_ADD; last_reg <= 1'b0;
            oval_reg <= '0; ostat_reg <= iiee_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next; ovalid_reg <= ovalid_next;
            op_reg <= op_next; last_reg <= last_next;
            oval_reg <= oval_next; ostat_reg <= ostat_next;
        end
    end

    assign out_ch.valid = ovalid_reg;
    assign out_ch.result_value = oval_reg;
    assign out_ch.status = ostat_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/infix_integer_expression_evaluator.sv =====
// top level of the infix integer expression evaluator
//
// usage: one character beat per item on in_ch (char_code, last_char); digits
// build a wrapping 32-bit number, + - * / are operators with two precedence
// levels, everything else is ignored. the beat with last_char set closes the
// expression and gives one result beat on out_ch (result_value, status).
// steps: a digit or ignored character is taken in the idle state; an operator
// first pushes the pending number, then folds each stacked operator of equal
// or higher precedence by one reduction, then is stacked; a reduction pops
// two values and computes, and for / by a nonzero value waits on the divider;
// a missing operand only sets the error flag. the closing beat pushes the
// pending number, folds all stacked operators and checks that one value is
// left, then emits. one item at a time: no new character until the last is done.
// reset clears the stacks, accumulator and error flag; no result is pending.
// a stalled receiver holds the result register; the next expression may be
// taken in but its own result waits until the register drains.
`timescale 1ns / 1ps
`default_nettype none
module infix_integer_expression_evaluator (
    input  wire logic  clk,
    input  wire logic  rst_n,
    iiee_in_if.sink    in_ch,
    iiee_out_if.source out_ch
);
    iiee_pkg::dp_cmd_t  cmd;
    iiee_pkg::dp_stat_t stat;
    logic [31:0] dp_value;
    logic [1:0]  dp_status;

    // sequencing of characters and reductions
    iiee_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .stat(stat), .cmd(cmd),
        .dp_value(dp_value), .dp_status(dp_status), .out_ch(out_ch)
    );

    // stacks and arithmetic
    iiee_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .result_value(dp_value), .status(dp_status)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/iiee_checker.sv =====
// port-level checks of the evaluator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module iiee_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [31:0] out_value,
    input wire logic [1:0] out_status
);
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_status != iiee_pkg::ST_SPARE)) else $error("bad status");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_status != iiee_pkg::ST_OK) |-> (out_value == 32'd0))
        else $error("error value");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_value))) else $error("drop");
    a_hold_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(out_status)) else $error("status changed");
endmodule

bind infix_integer_expression_evaluator iiee_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_value(out_ch.result_value), .out_status(out_ch.status)
);
`default_nettype wire

// ===== bench/infix_integer_expression_evaluator_test.sv =====
// testbench of the infix integer expression evaluator: random and directed expressions
`timescale 1ns / 1ps
`default_nettype none
module infix_integer_expression_evaluator_test;
    // expected result of one closed expression
    typedef struct {
        logic signed [31:0] value;
        iiee_pkg::status_t  status;
    } expr_result_t;

    // tracks evaluator state and queues the results it should give
    class expr_scoreboard;
        logic [31:0]       vals [iiee_pkg::STACK_DEPTH];
        int                nvals;
        iiee_pkg::op_t     ops [iiee_pkg::STACK_DEPTH];
        int                nops;
        logic [31:0]       acc;
        bit                acc_live;
        iiee_pkg::status_t err;
        expr_result_t      pending [$];
        int                failures;

        function new();
            failures = 0;
            clear_state();
        endfunction

        function void clear_state();
            nvals = 0;
            nops = 0;
            acc = '0;
            acc_live = 0;
            err = iiee_pkg::ST_OK;
        endfunction

        function void flag(iiee_pkg::status_t s);
            if (err == iiee_pkg::ST_OK)
                err = s;
        endfunction

        function void push_val(logic [31:0] v);
            if (nvals >= iiee_pkg::STACK_DEPTH)
            begin
                flag(iiee_pkg::ST_MISSING);
                return;
            end
            vals[nvals] = v;
            nvals++;
        endfunction

        function void fold_top();
            iiee_pkg::op_t o;
            logic signed [31:0] a, b;
            logic [31:0] r;
            if (nops == 0)
                return;
            nops--;
            o = ops[nops];
            if (nvals < 2)
            begin
                flag(iiee_pkg::ST_MISSING);
                return;
            end
            b = vals[nvals-1];
            a = vals[nvals-2];
            nvals -= 2;
            case (o)
                iiee_pkg::OP_ADD: r = a + b;
                iiee_pkg::OP_SUB: r = a - b;
                iiee_pkg::OP_MUL: r = a * b;
                default:
                begin
                    if (b == 0)
                    begin
                        flag(iiee_pkg::ST_DIVZERO);
                        r = '0;
                    end
                    else if (a == 32'sh8000_0000 && b == -1)
                        r = a;
                    else
                        r = a / b;
                end
            endcase
            push_val(r);
        endfunction

        function void flush_acc();
            if (acc_live)
            begin
                push_val(acc);
                acc = '0;
                acc_live = 0;
            end
        endfunction

        function void take_op(iiee_pkg::op_t o);
            flush_acc();
            while (nops > 0 && ops[nops-1][1] >= o[1])
                fold_top();
            if (nops >= iiee_pkg::STACK_DEPTH)
            begin
                flag(iiee_pkg::ST_MISSING);
                return;
            end
            ops[nops] = o;
            nops++;
        endfunction

        // called for every accepted character beat
        function void note_char(logic [7:0] c, logic last);
            expr_result_t e;
            if (c >= iiee_pkg::CH_ZERO && c <= iiee_pkg::CH_NINE)
            begin
                acc = acc * 10 + 32'(c - iiee_pkg::CH_ZERO);
                acc_live = 1;
            end
            else if (c == iiee_pkg::CH_PLUS)  take_op(iiee_pkg::OP_ADD);
            else if (c == iiee_pkg::CH_MINUS) take_op(iiee_pkg::OP_SUB);
            else if (c == iiee_pkg::CH_STAR)  take_op(iiee_pkg::OP_MUL);
            else if (c == iiee_pkg::CH_SLASH) take_op(iiee_pkg::OP_DIV);
            if (!last)
                return;
            flush_acc();
            while (nops > 0)
                fold_top();
            if (err == iiee_pkg::ST_OK && nvals != 1)
                flag(iiee_pkg::ST_MISSING);
            e.status = err;
            e.value = (err == iiee_pkg::ST_OK) ? vals[0] : '0;
            pending.push_back(e);
            clear_state();
        endfunction

        function void check_result(logic signed [31:0] v, logic [1:0] s);
            expr_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result value %0d status %0d", $time, v, s);
                failures++;
                return;
            end
            e = pending.pop_front();
            if (v !== e.value)
            begin
                $display("%0t: result_value expected %0d actual %0d", $time, e.value, v);
                failures++;
            end
            if (s !== e.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, s);
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    iiee_in_if  in_ch (clk);
    iiee_out_if out_ch (clk);

    infix_integer_expression_evaluator i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    expr_scoreboard board;
    int  cycle_count;
    int  sent_count;     // character beats accepted so far
    bit  calm;           // long stretch with no idling on either side

    localparam int CYCLE_LIMIT = 2_000_000;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // idle roughly 27 beats in a hundred unless in the calm stretch
    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 27);
    endfunction

    // one character beat, with random gaps before it
    task automatic send_char(logic [7:0] c, logic last);
        while (idle_now())
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.char_code <= c;
        in_ch.last_char <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        board.note_char(c, last);
        sent_count++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    // random number text, mostly short, sometimes long enough to wrap
    function automatic string rand_number();
        string s;
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(11, 14) : $urandom_range(1, 4);
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(8'(iiee_pkg::CH_ZERO + $urandom_range(9)))};
        return s;
    endfunction

    function automatic string rand_op();
        case ($urandom_range(3))
            0: return "+";
            1: return "-";
            2: return "*";
            default: return "/";
        endcase
    endfunction

    // well-formed expression with occasional noise characters and breakage
    task automatic send_random_expr();
        string s;
        int terms;
        int mode;
        int noise;
        terms = $urandom_range(1, 6);
        mode = $urandom_range(9);
        noise = $urandom_range(1, 6);
        s = "";
        for (int t = 0; t < terms; t++)
        begin
            if (t > 0)
                s = {s, rand_op()};
            if ($urandom_range(7) == 0)
                s = {s, " "};
            // small divisors and zeros make division cases common
            if ($urandom_range(5) == 0)
                s = {s, string'(8'(iiee_pkg::CH_ZERO + $urandom_range(2)))};
            else
                s = {s, rand_number()};
        end
        if (mode == 0)
            s = {rand_op(), s};
        else if (mode == 1)
            s = {s, rand_op()};
        else if (mode == 2)
            for (int i = 0; i < noise; i++)
                s = {s, string'(8'($urandom_range(255)))};
        send_text(s);
    endtask

    // receiver: stalls at random and checks each result beat
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                board.check_result(out_ch.result_value, out_ch.status);
            out_ch.ready <= !idle_now();
        end
    end

    // timeout guard
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("infix_integer_expression_evaluator test failed");
                $finish;
            end
        end
    end

    initial
    begin
        int wait_cycles;
        board = new();
        calm = 0;
        sent_count = 0;
        in_ch.valid = 1'b0;
        in_ch.char_code = '0;
        in_ch.last_char = 1'b0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every operator, the special cases
        send_text("0");
        send_text("4294967295");            // wraps to -1
        send_text("2147483648/4294967295"); // most negative over minus one
        send_text("7-10");
        send_text("2+3*4-6/2");
        send_text("7/0+1");                 // division by zero
        send_text("-5");                    // operator lacking an operand
        send_text("1a2 3");                 // ignored chars join digits
        send_char(8'hff, 1'b1);             // empty expression
        send_text("1+2*3-4/5+6*7");         // deep stacks
        send_text("9*");

        // random expressions, a calm stretch in the middle
        while (sent_count < 950 && cycle_count < CYCLE_LIMIT / 2)
        begin
            calm = (sent_count > 300 && sent_count < 450);
            send_random_expr();
        end
        calm = 0;
        in_ch.valid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        // let any reduction still in flight settle
        wait_cycles = 0;
        while (wait_cycles < 200)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (board.failures == 0 && board.pending.size() == 0)
            $display("infix_integer_expression_evaluator test passed");
        else
            $display("infix_integer_expression_evaluator test failed");
        $finish;
    end
endmodule
`default_nettype wire
